[rtl/fbp_pkg.sv]
package fbp_pkg;

  // Board geometry and piece storage
  localparam logic [6:0] BOARD_SQUARES = 7'd64;
  localparam logic [6:0] KING_NONE     = 7'd64;
  localparam int         SLOT_DEPTH    = 32;
  localparam logic [5:0] PIECE_SLOTS   = 6'd32;

  // Status codes
  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR       = 3'd1;
  localparam logic [2:0] ST_TOO_MANY       = 3'd2;
  localparam logic [2:0] ST_KINGS_MISSING  = 3'd3;
  localparam logic [2:0] ST_UNKNOWN_RESULT = 3'd4;

  // Result codes, seen from white before the side-to-move flip
  localparam logic [1:0] RES_LOSS = 2'd0;
  localparam logic [1:0] RES_DRAW = 2'd1;
  localparam logic [1:0] RES_WIN  = 2'd2;

  // Token bits in the pattern mask
  localparam int PAT_WHITE = 0;
  localparam int PAT_WIN   = 1;
  localparam int PAT_DRAW  = 2;
  localparam int PAT_LOSS  = 3;

  // Last four bytes before a closing bracket
  localparam logic [31:0] TOK_WIN  = "[1.0";
  localparam logic [31:0] TOK_DRAW = "[0.5";
  localparam logic [31:0] TOK_LOSS = "[0.0";

  typedef struct packed {
    logic [7:0] character;
    logic       line_end;
  } in_payload_t;

  typedef struct packed {
    logic [63:0] occupancy;
    logic [63:0] pieces_low;
    logic [63:0] pieces_high;
    logic [5:0]  white_king_square;
    logic [5:0]  black_king_square;
    logic        black_to_move;
    logic [1:0]  mover_result;
    logic [2:0]  status;
  } out_payload_t;

  typedef struct packed {
    logic       is_piece;
    logic [3:0] code;
  } piece_t;

  // Map a byte to its piece code: P N B R Q K = 0..5, p n b r q k = 6..11
  function automatic piece_t piece_code(input logic [7:0] c);
    piece_t p;
    p.is_piece = 1'b1;
    case (c)
      "P":     p.code = 4'd0;
      "N":     p.code = 4'd1;
      "B":     p.code = 4'd2;
      "R":     p.code = 4'd3;
      "Q":     p.code = 4'd4;
      "K":     p.code = 4'd5;
      "p":     p.code = 4'd6;
      "n":     p.code = 4'd7;
      "b":     p.code = 4'd8;
      "r":     p.code = 4'd9;
      "q":     p.code = 4'd10;
      "k":     p.code = 4'd11;
      default: begin
        p.is_piece = 1'b0;
        p.code     = 4'd0;
      end
    endcase
    return p;
  endfunction

endpackage

[rtl/fen_board_packer_top.sv]
// Channel | Direction | Handshake              | Payload
// in_     | input     | in_valid / in_ready    | in_payload_t (character, line_end)
// out_    | output    | out_valid / out_ready  | out_payload_t (board record)
//
// One byte is taken every cycle unless a line_end byte waits on a stalled record.
// The byte register feeds the parser state update and, on line_end, the record register.
// Reset (rst_n low, synchronous) empties both registers and returns the parser state
// to an empty board with no kings and no tokens seen.
// A stalled record holds the byte stage only when that stage carries the next line_end;
// plain bytes keep flowing into the parser state.
module fen_board_packer_top
  import fbp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  in_payload_t  in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output out_payload_t out_data
);

  // Byte register
  logic        s1_valid_r, s1_valid_nxt;
  in_payload_t s1_r;

  // Parser state
  logic [6:0]  sq_r, sq_nxt;
  logic [5:0]  pcnt_r, pcnt_nxt;
  logic [63:0] occ_r, occ_nxt;
  logic [3:0]  nib_r   [SLOT_DEPTH];
  logic [3:0]  nib_nxt [SLOT_DEPTH];
  logic [6:0]  wk_r, wk_nxt;
  logic [6:0]  bk_r, bk_nxt;
  logic [31:0] recent_r, recent_nxt;
  logic [3:0]  pat_r, pat_nxt;
  logic [2:0]  err_r, err_nxt;

  // Record register
  logic         out_valid_r, out_valid_nxt;
  out_payload_t out_r, out_nxt;

  // Values after the current byte
  logic [6:0]  sq_w;
  logic [5:0]  pcnt_w;
  logic [63:0] occ_w;
  logic [3:0]  nib_w [SLOT_DEPTH];
  logic [6:0]  wk_w, bk_w;
  logic [31:0] recent_w;
  logic [3:0]  pat_w;
  logic [2:0]  err_w;

  logic [7:0]  c;
  piece_t      pc;
  logic        placing;
  logic        adv;
  logic [7:0]  sq_sum;
  logic [2:0]  err_fin;
  logic        stm;
  logic [1:0]  res;
  logic        res_known;
  logic [63:0] pk_low, pk_high;

  assign c       = s1_r.character;
  assign pc      = piece_code(c);
  assign placing = (sq_r < BOARD_SQUARES) && (err_r == ST_OK);

  // Advance the byte stage unless a record is blocked in the output register
  assign adv      = s1_valid_r && (!s1_r.line_end || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  // Parse one placement byte
  always_comb begin
    sq_w   = sq_r;
    pcnt_w = pcnt_r;
    occ_w  = occ_r;
    nib_w  = nib_r;
    wk_w   = wk_r;
    bk_w   = bk_r;
    err_w  = err_r;
    sq_sum = {1'b0, sq_r} + {4'd0, c[3:0]};
    if (placing) begin
      if (pc.is_piece) begin
        if (pcnt_r >= PIECE_SLOTS) begin
          err_w = ST_TOO_MANY;
        end else begin
          if (c == "K") begin
            wk_w = sq_r;
          end else if (c == "k") begin
            bk_w = sq_r;
          end
          occ_w[sq_r[5:0]]   = 1'b1;
          nib_w[pcnt_r[4:0]] = pc.code;
          pcnt_w             = pcnt_r + 6'd1;
          sq_w               = sq_r + 7'd1;
        end
      end else if (c inside {["1":"8"]}) begin
        sq_w = (sq_sum > {1'b0, BOARD_SQUARES}) ? BOARD_SQUARES : sq_sum[6:0];
      end else if (c != "/") begin
        err_w = ST_BAD_CHAR;
      end
    end
  end

  // Match the side-to-move and result tokens
  always_comb begin
    pat_w = pat_r;
    if (recent_r[7:0] == "w" && c == " ") begin
      pat_w[PAT_WHITE] = 1'b1;
    end
    if (c == "]") begin
      if (recent_r == TOK_WIN)  pat_w[PAT_WIN]  = 1'b1;
      if (recent_r == TOK_DRAW) pat_w[PAT_DRAW] = 1'b1;
      if (recent_r == TOK_LOSS) pat_w[PAT_LOSS] = 1'b1;
    end
    recent_w = {recent_r[23:0], c};
  end

  // Pack the piece codes into the two record words
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      pk_low[4*i +: 4]  = nib_w[i];
      pk_high[4*i +: 4] = nib_w[16 + i];
    end
  end

  // Build the record from the state after the line_end byte
  always_comb begin
    err_fin = (err_w == ST_OK && sq_w < BOARD_SQUARES) ? ST_BAD_CHAR : err_w;
    stm     = !pat_w[PAT_WHITE];
    res_known = 1'b1;
    if (pat_w[PAT_WIN]) begin
      res = RES_WIN;
    end else if (pat_w[PAT_DRAW]) begin
      res = RES_DRAW;
    end else if (pat_w[PAT_LOSS]) begin
      res = RES_LOSS;
    end else begin
      res       = RES_LOSS;
      res_known = 1'b0;
    end

    out_nxt.occupancy         = occ_w;
    out_nxt.pieces_low        = pk_low;
    out_nxt.pieces_high       = pk_high;
    out_nxt.white_king_square = (wk_w < KING_NONE) ? wk_w[5:0] : 6'd0;
    out_nxt.black_king_square = (bk_w < KING_NONE) ? bk_w[5:0] : 6'd0;
    out_nxt.black_to_move     = stm;
    out_nxt.mover_result      = (res_known && stm) ? (RES_WIN - res) : res;

    if (err_fin != ST_OK) begin
      out_nxt.status = err_fin;
    end else if (wk_w >= KING_NONE || bk_w >= KING_NONE) begin
      out_nxt.status = ST_KINGS_MISSING;
    end else if (!res_known) begin
      out_nxt.status = ST_UNKNOWN_RESULT;
    end else begin
      out_nxt.status = ST_OK;
    end
  end

  // Commit the state, or clear it after a record is issued
  always_comb begin
    sq_nxt     = sq_r;
    pcnt_nxt   = pcnt_r;
    occ_nxt    = occ_r;
    nib_nxt    = nib_r;
    wk_nxt     = wk_r;
    bk_nxt     = bk_r;
    recent_nxt = recent_r;
    pat_nxt    = pat_r;
    err_nxt    = err_r;
    if (adv) begin
      if (s1_r.line_end) begin
        sq_nxt     = '0;
        pcnt_nxt   = '0;
        occ_nxt    = '0;
        for (int i = 0; i < SLOT_DEPTH; i++) nib_nxt[i] = '0;
        wk_nxt     = KING_NONE;
        bk_nxt     = KING_NONE;
        recent_nxt = '0;
        pat_nxt    = '0;
        err_nxt    = ST_OK;
      end else begin
        sq_nxt     = sq_w;
        pcnt_nxt   = pcnt_w;
        occ_nxt    = occ_w;
        nib_nxt    = nib_w;
        wk_nxt     = wk_w;
        bk_nxt     = bk_w;
        recent_nxt = recent_w;
        pat_nxt    = pat_w;
        err_nxt    = err_w;
      end
    end
  end

  // Handshake state of both registers
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv && s1_r.line_end) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sq_r        <= '0;
      pcnt_r      <= '0;
      occ_r       <= '0;
      for (int i = 0; i < SLOT_DEPTH; i++) nib_r[i] <= '0;
      wk_r        <= KING_NONE;
      bk_r        <= KING_NONE;
      recent_r    <= '0;
      pat_r       <= '0;
      err_r       <= ST_OK;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      sq_r        <= sq_nxt;
      pcnt_r      <= pcnt_nxt;
      occ_r       <= occ_nxt;
      nib_r       <= nib_nxt;
      wk_r        <= wk_nxt;
      bk_r        <= bk_nxt;
      recent_r    <= recent_nxt;
      pat_r       <= pat_nxt;
      err_r       <= err_nxt;
    end
  end

  // Payload registers load without reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (adv && s1_r.line_end) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A record appears only after a line_end byte left the byte stage
  a_record_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv && s1_r.line_end))
    else $error("record issued without a line_end byte");

  // Issuing a record clears the parser state
  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_r.line_end) |=> (sq_r == '0 && pcnt_r == '0 && occ_r == '0
                                && pat_r == '0 && err_r == ST_OK))
    else $error("parser state not cleared after record");

  // Piece count never passes the slot count
  a_piece_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= PIECE_SLOTS)
    else $error("piece count past slot count");

  // Square count never passes the board
  a_square_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sq_r <= BOARD_SQUARES)
    else $error("square count past board");

endmodule
